[rtl/svtm_pkg.sv]
// svtm_pkg: shared widths, fixed-point constants and the arctangent table
// for the sphere vertex texture mapper; no dependencies
package svtm_pkg;

	localparam int COORD_W      = 16;
	localparam int U_W          = 16;
	localparam int V_W          = 18;
	localparam int DW           = 48;   // cordic x/y datapath
	localparam int AW           = 34;   // angles in q30 radians
	localparam int YW           = 32;   // clamped y in q30
	localparam int NW           = 61;   // square root radicand
	localparam int RW           = 31;   // square root result
	localparam int MW           = 31;   // log2 argument / mantissa
	localparam int PW           = 5;    // log2 integer part
	localparam int LW           = PW + 30;
	localparam int CORDIC_STEPS = 28;
	localparam int SQRT_STEPS   = 31;
	localparam int LOG_STEPS    = 30;

	localparam logic signed [DW-1:0] Q30_ONE     = 48'sd1073741824;
	localparam logic signed [AW-1:0] Q30_PI_HALF = 34'sd1686629713;
	localparam logic signed [AW-1:0] Q30_LAT_OFS = 34'sd1686622920;
	localparam logic signed [30:0]   Q30_INV_PI  = 31'sd341782638;
	localparam logic signed [YW-1:0] Q30_CLAMP   = 32'sd1073634450;
	localparam logic signed [28:0]   Q28_LN2     = 29'sd186065279;

	localparam logic signed [AW-1:0] ATAN_TAB [10] = '{
		34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
		34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
		34'sd4194283, 34'sd2097149
	};

	function automatic logic signed [AW-1:0] atan_step(input int i);
		logic signed [AW-1:0] r;
		r = '0;
		if (i < 10) begin
			r = ATAN_TAB[i];
		end else begin
			r[30-i] = 1'b1;
		end
		return r;
	endfunction

endpackage

[rtl/svtm_if.sv]
// svtm_if: valid/ready channel interfaces for vertex items and texture results
// depends on svtm_pkg for the field widths
interface svtm_vtx_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [svtm_pkg::COORD_W-1:0]  coord_x;
	logic signed [svtm_pkg::COORD_W-1:0]  coord_y;
	logic signed [svtm_pkg::COORD_W-1:0]  coord_z;
	logic                                 last_vertex;

	modport source (output valid, coord_x, coord_y, coord_z, last_vertex, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, last_vertex, output ready);
endinterface

interface svtm_uv_if;
	logic                             valid;
	logic                             ready;
	logic [svtm_pkg::U_W-1:0]         tex_u;
	logic signed [svtm_pkg::V_W-1:0]  tex_v;
	logic                             last_out;

	modport source (output valid, tex_u, tex_v, last_out, input ready);
	modport sink (input valid, tex_u, tex_v, last_out, output ready);
endinterface

[rtl/svtm_delay.sv]
// svtm_delay: enabled shift line that keeps side data in step with the pipeline
// no package dependency
module svtm_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] d_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				d_s[i] <= d_s[i-1];
			end
		end
	end

	assign dout = d_s[DEPTH-1];

endmodule

[rtl/svtm_cordic.sv]
// svtm_cordic: pipelined vectoring cordic giving atan2(a, b) in q30 radians
// depends on svtm_pkg; one pre-rotation stage followed by the CORDIC_STEPS iteration stages
module svtm_cordic (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [svtm_pkg::DW-1:0] a_in,
	input  logic signed [svtm_pkg::DW-1:0] b_in,
	output logic signed [svtm_pkg::AW-1:0] ang
);
	import svtm_pkg::*;

	logic signed [DW-1:0] cx_s [CORDIC_STEPS+1];
	logic signed [DW-1:0] cy_s [CORDIC_STEPS+1];
	logic signed [AW-1:0] cz_s [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			// quadrant fold for the left half plane
			if (b_in < 0) begin
				if (a_in >= 0) begin
					cx_s[0] <= a_in;
					cy_s[0] <= -b_in;
					cz_s[0] <= Q30_PI_HALF;
				end else begin
					cx_s[0] <= -a_in;
					cy_s[0] <= b_in;
					cz_s[0] <= -Q30_PI_HALF;
				end
			end else begin
				cx_s[0] <= b_in;
				cy_s[0] <= a_in;
				cz_s[0] <= '0;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (!cy_s[i][DW-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + atan_step(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - atan_step(i);
				end
			end
		end
	end

	assign ang = cz_s[CORDIC_STEPS];

endmodule

[rtl/svtm_isqrt.sv]
// svtm_isqrt: pipelined integer square root, one result bit per stage
// depends on svtm_pkg; radicand at most 2^60
module svtm_isqrt (
	input  logic                    clk,
	input  logic                    en,
	input  logic [svtm_pkg::NW-1:0] rad,
	output logic [svtm_pkg::RW-1:0] root
);
	import svtm_pkg::*;

	logic [NW-1:0] n_s  [SQRT_STEPS];
	logic [NW:0]   r_s  [SQRT_STEPS];
	logic [NW-1:0] nin  [SQRT_STEPS];
	logic [NW:0]   rin  [SQRT_STEPS];
	logic [NW:0]   trial[SQRT_STEPS];
	logic [NW-1:0] nx   [SQRT_STEPS];
	logic [NW:0]   rx   [SQRT_STEPS];

	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			nin[k] = (k == 0) ? rad : n_s[(k == 0) ? 0 : k-1];
			rin[k] = (k == 0) ? '0 : r_s[(k == 0) ? 0 : k-1];
			trial[k] = rin[k] + ((NW+1)'(1) << (NW - 1 - 2*k));
			if ({1'b0, nin[k]} >= trial[k]) begin
				nx[k] = nin[k] - trial[k][NW-1:0];
				rx[k] = (rin[k] >> 1) + ((NW+1)'(1) << (NW - 1 - 2*k));
			end else begin
				nx[k] = nin[k];
				rx[k] = rin[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STEPS; k++) begin
				n_s[k] <= nx[k];
				r_s[k] <= rx[k];
			end
		end
	end

	assign root = r_s[SQRT_STEPS-1][RW-1:0];

endmodule

[rtl/svtm_log2.sv]
// svtm_log2: pipelined log2 with 30 fraction bits by repeated squaring
// depends on svtm_pkg; one normalize stage then one squaring per stage
module svtm_log2 (
	input  logic                    clk,
	input  logic                    en,
	input  logic [svtm_pkg::MW-1:0] arg,
	output logic [svtm_pkg::LW-1:0] lg
);
	import svtm_pkg::*;

	logic [PW-1:0]   p0;
	logic [MW-1:0]   m0;
	logic [MW-1:0]   m_s [LOG_STEPS+1];
	logic [PW-1:0]   p_s [LOG_STEPS+1];
	logic [29:0]     f_s [LOG_STEPS+1];
	logic [2*MW-1:0] sq  [LOG_STEPS];

	always_comb begin
		p0 = '0;
		for (int j = 0; j < MW; j++) begin
			if (arg[j]) begin
				p0 = PW'(j);
			end
		end
		m0 = arg << (PW'(MW - 1) - p0);
		for (int k = 0; k < LOG_STEPS; k++) begin
			sq[k] = (2*MW)'(m_s[k]) * (2*MW)'(m_s[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= m0;
			p_s[0] <= p0;
			f_s[0] <= '0;
			for (int k = 0; k < LOG_STEPS; k++) begin
				p_s[k+1] <= p_s[k];
				if (sq[k][61]) begin
					m_s[k+1] <= sq[k][61:31];
					f_s[k+1] <= f_s[k] | (30'(1) << (29 - k));
				end else begin
					m_s[k+1] <= sq[k][60:30];
					f_s[k+1] <= f_s[k];
				end
			end
		end
	end

	assign lg = {p_s[LOG_STEPS], f_s[LOG_STEPS]};

endmodule

[rtl/sphere_vertex_texture_mapper.sv]
// Sphere vertex texture mapper: takes one unit-sphere vertex per item and
// returns its texture coordinates u (longitude) and v (latitude, plain or
// Mercator by proj_mode). A new item is taken every cycle unless the result
// side stalls; the pipeline depth is set by the latitude path (square root of
// 31 stages followed by a 29-stage cordic). When the result side stalls, the
// whole pipeline holds and input ready drops until the held result is taken.
// Depends on svtm_pkg, svtm_if, svtm_delay, svtm_cordic, svtm_isqrt, svtm_log2.
module sphere_vertex_texture_mapper #(
	parameter int FRAC_BITS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	svtm_vtx_if.sink   vtx,
	svtm_uv_if.source  uv
);
	import svtm_pkg::*;

	localparam int SH        = 30 - FRAC_BITS;
	localparam int LON_LAT   = CORDIC_STEPS + 1;
	localparam int EQ_LAT    = 1 + SQRT_STEPS + LON_LAT;
	localparam int MERC_LAT  = LOG_STEPS + 3;
	localparam int NSTG      = EQ_LAT + 3;
	localparam int RDW       = 37;

	localparam logic signed [RDW-1:0] HALF_LSB = RDW'(1) << (SH - 1);
	localparam logic signed [RDW-1:0] U_ONE    = RDW'(1) << FRAC_BITS;
	localparam logic signed [RDW-1:0] U_MAX    = RDW'(1) << (FRAC_BITS + 1);
	localparam logic signed [RDW-1:0] V_MAX    = 37'sd131071;
	localparam logic signed [RDW-1:0] V_MIN    = -37'sd131072;

	logic adv;
	logic proj_mode_q;
	logic [NSTG-1:0] vld_s;

	// input scaling and classification
	logic signed [DW-1:0] xw, yw, zw;
	logic signed [YW-1:0] ycw;

	logic signed [DW-1:0] x_s1, z_s1;
	logic signed [YW-1:0] yc_s1;
	logic                 pole_s1, axis_s1, last_s1;

	assign adv       = !vld_s[NSTG-1] || uv.ready;
	assign vtx.ready = adv;

	always_comb begin
		xw = DW'(vtx.coord_x) <<< SH;
		yw = DW'(vtx.coord_y) <<< SH;
		zw = DW'(vtx.coord_z) <<< SH;
		if (yw > DW'(Q30_CLAMP)) begin
			ycw = Q30_CLAMP;
		end else if (yw < -DW'(Q30_CLAMP)) begin
			ycw = -Q30_CLAMP;
		end else begin
			ycw = YW'(yw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			proj_mode_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				proj_mode_q <= cfg_wdata;
			end
			if (adv) begin
				vld_s <= {vld_s[NSTG-2:0], vtx.valid};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= xw;
			z_s1    <= zw;
			yc_s1   <= ycw;
			pole_s1 <= (yw >= Q30_ONE) || (yw <= -Q30_ONE);
			axis_s1 <= (vtx.coord_x == '0) && (vtx.coord_z == '0);
			last_s1 <= vtx.last_vertex;
		end
	end

	// longitude
	logic signed [AW-1:0] lon_s30, lon_s62;

	svtm_cordic u_lon (
		.clk  (clk),
		.en   (adv),
		.a_in (x_s1),
		.b_in (z_s1),
		.ang  (lon_s30)
	);

	svtm_delay #(.W(AW), .DEPTH(EQ_LAT - LON_LAT)) u_lon_dly (
		.clk  (clk),
		.en   (adv),
		.din  (lon_s30),
		.dout (lon_s62)
	);

	// plain latitude: atan2(y, sqrt(1 - y^2))
	logic [29:0]          ya;
	logic [NW-1:0]        nsq_s2;
	logic [RW-1:0]        root_s33;
	logic signed [YW-1:0] yc_s33;
	logic signed [AW-1:0] elat_s62;

	assign ya = yc_s1[YW-1] ? 30'(-yc_s1) : yc_s1[29:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			nsq_s2 <= (NW'(1) << 60) - NW'(60'(ya) * 60'(ya));
		end
	end

	svtm_isqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (nsq_s2),
		.root (root_s33)
	);

	svtm_delay #(.W(YW), .DEPTH(1 + SQRT_STEPS)) u_yc_dly (
		.clk  (clk),
		.en   (adv),
		.din  (yc_s1),
		.dout (yc_s33)
	);

	svtm_cordic u_lat (
		.clk  (clk),
		.en   (adv),
		.a_in (DW'(yc_s33)),
		.b_in ($signed({{(DW-RW){1'b0}}, root_s33})),
		.ang  (elat_s62)
	);

	// mercator latitude: ln2 * (log2(1 + y) - log2(1 - y)) / 2
	logic [YW-1:0]           np_w, nm_w;
	logic [LW-1:0]           lp_s32, lm_s32;
	logic signed [LW:0]      d_s33;
	logic signed [LW+29:0]   dprod;
	logic signed [AW-1:0]    mlat_s34, mlat_s62;

	assign np_w  = YW'(32'sd1073741824 + yc_s1);
	assign nm_w  = YW'(32'sd1073741824 - yc_s1);
	assign dprod = d_s33 * Q28_LN2;

	svtm_log2 u_logp (
		.clk (clk),
		.en  (adv),
		.arg (np_w[MW-1:0]),
		.lg  (lp_s32)
	);

	svtm_log2 u_logm (
		.clk (clk),
		.en  (adv),
		.arg (nm_w[MW-1:0]),
		.lg  (lm_s32)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s33    <= $signed({1'b0, lp_s32}) - $signed({1'b0, lm_s32});
			mlat_s34 <= AW'(dprod >>> 29);
		end
	end

	svtm_delay #(.W(AW), .DEPTH(EQ_LAT - MERC_LAT)) u_merc_dly (
		.clk  (clk),
		.en   (adv),
		.din  (mlat_s34),
		.dout (mlat_s62)
	);

	// side flags
	logic [2:0] side_s62;

	svtm_delay #(.W(3), .DEPTH(EQ_LAT)) u_side_dly (
		.clk  (clk),
		.en   (adv),
		.din  ({pole_s1, axis_s1, last_s1}),
		.dout (side_s62)
	);

	// scale by 1/pi
	logic signed [AW-1:0] lat_w, lon_w;
	logic signed [AW:0]   vsum_w;
	logic signed [AW+30:0] pu_s63;
	logic signed [AW+31:0] pv_s63;
	logic                  pole_s63, last_s63;

	always_comb begin
		lat_w  = proj_mode_q ? mlat_s62 : elat_s62;
		lon_w  = side_s62[1] ? '0 : lon_s62;
		vsum_w = (AW+1)'(lat_w) + (AW+1)'(Q30_LAT_OFS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s63   <= lon_w * Q30_INV_PI;
			pv_s63   <= vsum_w * Q30_INV_PI;
			pole_s63 <= side_s62[2];
			last_s63 <= side_s62[0];
		end
	end

	// round to output precision and saturate; u is forced to one at the poles
	logic signed [RDW-1:0] us_w, ur_w, vs_w, vr_w;
	logic [U_W-1:0]        uo_w;
	logic [V_W-1:0]        vo_w;

	always_comb begin
		us_w = RDW'(pu_s63 >>> 30) + RDW'(Q30_ONE);
		ur_w = (us_w + HALF_LSB) >>> SH;
		if (pole_s63) begin
			ur_w = U_ONE;
		end else if (ur_w < 0) begin
			ur_w = '0;
		end else if (ur_w > U_MAX) begin
			ur_w = U_MAX;
		end
		uo_w = ur_w[U_W-1:0];
		vs_w = RDW'(pv_s63 >>> 30);
		vr_w = (vs_w + HALF_LSB) >>> SH;
		if (vr_w > V_MAX) begin
			vr_w = V_MAX;
		end else if (vr_w < V_MIN) begin
			vr_w = V_MIN;
		end
		vo_w = vr_w[V_W-1:0];
	end

	logic [U_W-1:0]        u_s64;
	logic signed [V_W-1:0] v_s64;
	logic                  last_s64;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s64    <= uo_w;
			v_s64    <= $signed(vo_w);
			last_s64 <= last_s63;
		end
	end

	assign uv.valid    = vld_s[NSTG-1];
	assign uv.tex_u    = u_s64;
	assign uv.tex_v    = v_s64;
	assign uv.last_out = last_s64;

endmodule
